FILE: hw/rtl/pct_pkg.sv
package pct_pkg;

    // Number of table entries, one chain cell per entry.
    localparam int TABLE_ENTRIES = 64;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [5:0]  MAX_LEN  = 6'd32;

    typedef enum logic [0:0] {
        OP_MAP  = 1'b0,
        OP_FIND = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    // Query token that travels down the chain, one cell per cycle.
    typedef struct packed {
        logic        active;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [31:0] key;
        logic        conflict;
        logic        hit;
        logic [31:0] hit_client;
        logic        free_seen;
    } pct_tok_t;

    // Update broadcast to every cell once the walk has finished.
    typedef struct packed {
        logic        write_same;
        logic        write_free;
        logic [31:0] key;
        logic [5:0]  len;
        logic [31:0] client;
    } pct_commit_t;

    // Mask that keeps the low len bits; a length of 32 keeps the whole word.
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len >= MAX_LEN)
        begin
            m = ALL_ONES;
        end
        else
        begin
            m = (32'd1 << len[4:0]) - 32'd1;
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/pct_cell.sv
module pct_cell
    import pct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pct_tok_t    tok_in,
    input  pct_commit_t commit,
    output pct_tok_t    tok_out
);

    logic        valid_reg;
    logic [31:0] prefix_reg;
    logic [5:0]  length_reg;
    logic [31:0] client_reg;
    logic        cand_same_reg;
    logic        cand_free_reg;
    logic        act_reg;
    pct_tok_t    tok_reg;

    logic        same;
    logic        first_free;
    logic        conflict;
    pct_tok_t    tok_next;

    always_comb
    begin
        same       = 1'b0;
        conflict   = 1'b0;
        first_free = !valid_reg && !tok_in.free_seen;
        if (valid_reg)
        begin
            if (length_reg < tok_in.len)
            begin
                conflict = ((tok_in.addr & len_mask(length_reg)) == prefix_reg)
                           && (client_reg != ALL_ONES);
            end
            else if (length_reg > tok_in.len)
            begin
                conflict = ((prefix_reg & len_mask(tok_in.len)) == tok_in.key);
            end
            else
            begin
                same = (prefix_reg == tok_in.key);
            end
        end
        tok_next            = tok_in;
        tok_next.conflict   = tok_in.conflict | conflict;
        tok_next.hit        = tok_in.hit | same;
        tok_next.hit_client = same ? client_reg : tok_in.hit_client;
        tok_next.free_seen  = tok_in.free_seen | !valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            act_reg   <= 1'b0;
        end
        else
        begin
            act_reg <= tok_in.active;
            if (commit.write_free && cand_free_reg)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (tok_in.active)
        begin
            cand_same_reg <= same;
            cand_free_reg <= first_free;
        end
        if (commit.write_free && cand_free_reg)
        begin
            prefix_reg <= commit.key;
            length_reg <= commit.len;
            client_reg <= commit.client;
        end
        else if (commit.write_same && cand_same_reg)
        begin
            client_reg <= commit.client;
        end
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = act_reg;
    end

endmodule

FILE: hw/rtl/pct_chain.sv
module pct_chain
    import pct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pct_tok_t    tok_in,
    input  pct_commit_t commit,
    output pct_tok_t    tok_out
);

    pct_tok_t link [TABLE_ENTRIES+1];

    assign link[0] = tok_in;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        pct_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[g]),
            .commit  (commit),
            .tok_out (link[g+1])
        );
    end

    assign tok_out = link[TABLE_ENTRIES];

endmodule

FILE: hw/rtl/prefix_client_table_top.sv
// Prefix to client table.
// The input channel (in_valid/in_ready) carries one beat per request: opcode
// selects a map (store client_id for the low prefix_len bits of address) or a
// find (return the client stored for exactly that prefix). The output channel
// (out_valid/out_ready) returns one beat per request with status and
// found_client; found_client is all-ones for every map and for a missed find.
// The table is a chain of TABLE_ENTRIES cells, one entry per cell. A request
// token walks the chain one cell per cycle, gathering conflict, hit and
// free-entry flags; at the end of the walk a single broadcast writes the
// chosen cell. One request is in the block at a time, so its result beat
// waits until its token has passed every cell of the chain. A request whose
// prefix length is over 32 skips the walk and goes straight to its result.
// An asynchronous reset empties the table and drops any request in flight.
// The result sits in an output register, so a stall on out_ready does not
// block the next request; only when a second result is ready while the first
// has still not been taken does the block wait before going idle again.
module prefix_client_table_top
    import pct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [0:0]  opcode,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_len,
    input  logic [31:0] client_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] found_client
);

    state_t      state_reg, state_next;
    op_t         op_reg;
    logic [31:0] key_reg;
    logic [5:0]  len_reg;
    logic [31:0] client_reg;
    status_t     res_status_reg, res_status_next;
    logic [31:0] res_found_reg, res_found_next;
    logic        out_valid_reg;
    status_t     status_reg;
    logic [31:0] found_client_reg;

    logic        accept;
    logic        len_bad;
    logic        out_load;
    pct_tok_t    tok_launch;
    pct_tok_t    tok_last;
    pct_commit_t commit;

    assign accept  = in_valid && in_ready;
    assign len_bad = prefix_len > MAX_LEN;

    // The token enters the first cell in the same cycle as the request beat.
    always_comb
    begin
        tok_launch            = '0;
        tok_launch.active     = accept && !len_bad;
        tok_launch.addr       = address;
        tok_launch.len        = prefix_len;
        tok_launch.key        = address & len_mask(prefix_len);
        tok_launch.hit_client = ALL_ONES;
    end

    pct_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok_launch),
        .commit  (commit),
        .tok_out (tok_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(opcode);
            key_reg    <= address & len_mask(prefix_len);
            len_reg    <= prefix_len;
            client_reg <= client_id;
        end
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        if (out_load)
        begin
            status_reg       <= res_status_reg;
            found_client_reg <= res_found_reg;
        end
    end

    // Controller: wait for a request, pass an over-length one to its result, or
    // run its token down the chain, deciding and committing at the last cell.
    always_comb
    begin
        state_next        = state_reg;
        res_status_next   = res_status_reg;
        res_found_next    = res_found_reg;
        in_ready          = 1'b0;
        out_load          = 1'b0;
        commit            = '0;
        commit.key        = key_reg;
        commit.len        = len_reg;
        commit.client     = client_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (len_bad)
                    begin
                        res_status_next = ST_BAD_LEN;
                        res_found_next  = ALL_ONES;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (tok_last.active)
                begin
                    res_status_next = ST_OK;
                    res_found_next  = ALL_ONES;
                    if (op_reg == OP_FIND)
                    begin
                        res_found_next = tok_last.hit_client;
                    end
                    else if (tok_last.conflict)
                    begin
                        res_status_next = ST_CONFLICT;
                    end
                    else if (tok_last.hit)
                    begin
                        commit.write_same = 1'b1;
                    end
                    else if (tok_last.free_seen)
                    begin
                        commit.write_free = 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_client = found_client_reg;

    // Only one of the two write kinds may fire for an item.
    a_commit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(commit.write_same && commit.write_free))
        else $error("same-prefix and free-entry writes fired together");

    // The table is written only on behalf of a map request.
    a_commit_map_only: assert property (@(posedge clk) disable iff (!rst_n)
        (commit.write_same || commit.write_free) |-> (op_reg == OP_MAP))
        else $error("table written for a find request");

    // A token can only leave the chain while the controller is walking.
    a_token_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.active |-> (state_reg == S_WALK))
        else $error("token left the chain outside a walk");

    // An over-length request goes straight to its result.
    a_bad_len_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && len_bad) |=> (state_reg == S_DONE && res_status_reg == ST_BAD_LEN))
        else $error("over-length request did not answer at once");

endmodule

FILE: tb/prefix_client_table_top_tb.sv
module prefix_client_table_top_tb;

    import pct_pkg::*;

    // The run is bounded by this many clock cycles. A correct run needs
    // roughly 1450 requests, plus gaps and stalls.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Length of the deliberate receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 500;
    // Cycles allowed after the last result for anything stray to turn up.
    localparam int DRAIN_CYCLES = 100;

    // One expected result beat.
    typedef struct {
        status_t     code;
        logic [31:0] client;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [0:0]  opcode = OP_MAP;
    logic [31:0] address = '0;
    logic [5:0]  prefix_len = '0;
    logic [31:0] client_id = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] found_client;

    // Our own copy of the prefix table. Entries are never freed, so the
    // occupied slots are always 0 .. slots_filled-1.
    logic        slot_used   [TABLE_ENTRIES];
    logic [31:0] slot_prefix [TABLE_ENTRIES];
    logic [5:0]  slot_len    [TABLE_ENTRIES];
    logic [31:0] slot_client [TABLE_ENTRIES];
    int          slots_filled = 0;

    // Results still owed by the block, oldest first.
    reply_t pending_replies[$];

    int mismatches = 0;
    int cycle_count = 0;

    // When steady is set neither side inserts random idle cycles.
    logic steady = 1'b0;
    // Toggling hold_flag asks the receiver process for one long hold-off.
    logic hold_flag = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    prefix_client_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .address      (address),
        .prefix_len   (prefix_len),
        .client_id    (client_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_client (found_client)
    );

    always #5 clk = ~clk;

    // Run-length guard: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mask keeping the low n bits of a word; a shift by the full width of 32
    // yields zero, so a length of zero gives an empty mask.
    function automatic logic [31:0] low_bits(input logic [5:0] n);
        return 32'hffff_ffff >> (32 - int'(n));
    endfunction

    // A random address whose low n bits carry the given prefix.
    function automatic logic [31:0] with_prefix(input logic [31:0] prefix,
                                                input logic [5:0] n);
        return ($urandom() & ~low_bits(n)) | prefix;
    endfunction

    // Works out the result beat for one accepted request and applies any
    // table update it causes. Shorter stored prefixes only block when their
    // client is not all-ones; longer stored prefixes always block. Conflicts
    // take priority over an exact overwrite, which in turn takes priority
    // over the table being full.
    function automatic void predict_reply(input op_t op, input logic [31:0] addr,
                                          input logic [5:0] len,
                                          input logic [31:0] client,
                                          output reply_t r);
        logic [31:0] key;
        int          same_idx;
        int          free_idx;
        logic        clash;
        logic        hit;
        r.code = ST_OK;
        r.client = ALL_ONES;
        key = addr & low_bits(len);
        same_idx = -1;
        free_idx = -1;
        clash = 1'b0;
        hit = 1'b0;
        if (len > MAX_LEN)
        begin
            r.code = ST_BAD_LEN;
        end
        else if (op == OP_FIND)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (!hit && slot_used[i] && slot_len[i] == len && slot_prefix[i] == key)
                begin
                    hit = 1'b1;
                    r.client = slot_client[i];
                end
            end
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (!slot_used[i])
                begin
                    if (free_idx < 0)
                        free_idx = i;
                end
                else if (slot_len[i] < len)
                begin
                    if ((addr & low_bits(slot_len[i])) == slot_prefix[i]
                        && slot_client[i] != ALL_ONES)
                        clash = 1'b1;
                end
                else if (slot_len[i] > len)
                begin
                    if ((slot_prefix[i] & low_bits(len)) == key)
                        clash = 1'b1;
                end
                else if (slot_prefix[i] == key)
                begin
                    same_idx = i;
                end
            end
            if (clash)
                r.code = ST_CONFLICT;
            else if (same_idx >= 0)
                slot_client[same_idx] = client;
            else if (free_idx < 0)
                r.code = ST_FULL;
            else
            begin
                slot_used[free_idx] = 1'b1;
                slot_prefix[free_idx] = key;
                slot_len[free_idx] = len;
                slot_client[free_idx] = client;
                slots_filled++;
            end
        end
    endfunction

    // Offers one request beat and waits for it to be accepted. Any idle gap
    // is taken first, with valid low, so valid never drops once raised. The
    // acceptance is seen just after the rising edge, before the block's own
    // registers have moved.
    task automatic send_request(input op_t op, input logic [31:0] addr,
                                input logic [5:0] len, input logic [31:0] client);
        int     gap;
        reply_t r;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 24)
        begin
            // Mostly short gaps, now and then one long enough to land on
            // any point of the block's walk down the chain.
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(4, 80);
            else
                gap = $urandom_range(1, 3);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        address    <= addr;
        prefix_len <= len;
        client_id  <= client;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_reply(op, addr, len, client, r);
        pending_replies.push_back(r);
    endtask

    // Draws one random request, shaped around what the table holds so that
    // hits, overwrites and both kinds of conflict turn up often.
    task automatic pick_request(output op_t op, output logic [31:0] addr,
                                output logic [5:0] len, output logic [31:0] client);
        int          roll;
        int          idx;
        int          base_len;
        logic [31:0] base_prefix;
        roll = $urandom_range(0, 99);
        idx = $urandom_range(0, slots_filled - 1);
        base_len = int'(slot_len[idx]);
        base_prefix = slot_prefix[idx];
        op = OP_MAP;
        client = $urandom();
        if ($urandom_range(0, 7) == 0)
            client = ALL_ONES;
        // By default a fresh prefix, usually long so that it rarely covers
        // much of what is already stored.
        addr = $urandom();
        len = 6'($urandom_range(20, 32));
        if ($urandom_range(0, 2) == 0)
            len = 6'($urandom_range(1, 32));
        if (roll < 25)
        begin
            // Exact find of a stored prefix, with noise in the upper bits.
            op = OP_FIND;
            len = 6'(base_len);
            addr = with_prefix(base_prefix, len);
        end
        else if (roll < 35)
        begin
            op = OP_FIND;
            len = 6'($urandom_range(0, 32));
        end
        else if (roll < 53)
        begin
            // Overwrite of a stored prefix.
            len = 6'(base_len);
            addr = with_prefix(base_prefix, len);
        end
        else if (roll < 68 && base_len < 32)
        begin
            // A longer prefix that lies under a stored one.
            len = 6'($urandom_range(base_len + 1, 32));
            addr = with_prefix(base_prefix, 6'(base_len));
        end
        else if (roll < 78 && base_len > 0)
        begin
            // A shorter prefix that covers a stored one.
            len = 6'($urandom_range(0, base_len - 1));
            addr = with_prefix(base_prefix, 6'(base_len));
        end
        else if (roll >= 78 && roll < 86)
        begin
            op = op_t'($urandom_range(0, 1));
            len = 6'($urandom_range(33, 63));
        end
    endtask

    // Receiver side. A requested hold-off is counted down here, cycle by
    // cycle; otherwise ready is low about a quarter of the time unless the
    // current phase runs without idling.
    always @(negedge clk)
    begin
        if (hold_flag != hold_seen)
        begin
            hold_seen = hold_flag;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 24);
    end

    // Every result beat is compared with the oldest outstanding expectation.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result beat with nothing outstanding: status %0d, found_client %h",
                       status, found_client);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.code)
                begin
                    $error("status: expected %0d, actual %0d", want.code, status);
                    mismatches++;
                end
                if (found_client !== want.client)
                begin
                    $error("found_client: expected %h, actual %h", want.client, found_client);
                    mismatches++;
                end
            end
        end
    end

    // Corner cases on an empty table: the zero-length prefix, an all-ones
    // client that does not block, overwrites in place, both kinds of
    // overlap, lengths over 32 on map and find, and hits and misses.
    task automatic test_directed_corners();
        send_request(OP_MAP,  32'h0000_0000, 6'd0,  ALL_ONES);
        send_request(OP_FIND, 32'hffff_ffff, 6'd0,  32'h0000_0000);
        send_request(OP_MAP,  32'h1234_5678, 6'd0,  32'h0000_0000);
        send_request(OP_FIND, 32'h0000_0000, 6'd0,  ALL_ONES);
        // Blocked by the zero-length prefix, whose client is now zero.
        send_request(OP_MAP,  32'hffff_ffff, 6'd32, 32'h0000_0005);
        // Back to all-ones, which no longer blocks longer prefixes.
        send_request(OP_MAP,  32'h0000_0000, 6'd0,  ALL_ONES);
        send_request(OP_MAP,  32'hffff_ffff, 6'd32, 32'h0000_0000);
        send_request(OP_FIND, 32'hffff_ffff, 6'd32, ALL_ONES);
        // The zero-length prefix now covers a longer one, so this fails.
        send_request(OP_MAP,  32'h0000_0000, 6'd0,  32'h0000_0007);
        send_request(OP_MAP,  32'h0000_0000, 6'd33, 32'h0000_0000);
        send_request(OP_FIND, 32'hffff_ffff, 6'd63, ALL_ONES);
        send_request(OP_MAP,  32'h0000_0000, 6'd32, ALL_ONES);
        send_request(OP_FIND, 32'h0000_0000, 6'd32, 32'h0000_0000);
        send_request(OP_MAP,  32'h0000_00a5, 6'd8,  32'hdead_beef);
        send_request(OP_MAP,  32'hffff_ffa5, 6'd16, 32'h0000_0001);
        send_request(OP_MAP,  32'h0000_0005, 6'd4,  32'h0000_0002);
        // Same prefix with different upper bits overwrites in place.
        send_request(OP_MAP,  32'h1200_00a5, 6'd8,  ALL_ONES);
        send_request(OP_MAP,  32'h0000_12a5, 6'd16, 32'h0000_0003);
        send_request(OP_FIND, 32'habcd_12a5, 6'd16, 32'h0000_0000);
        send_request(OP_FIND, 32'h0000_00a5, 6'd8,  32'h0000_0000);
        send_request(OP_FIND, 32'h5555_5555, 6'd31, 32'h0000_0000);
        send_request(OP_MAP,  32'h0000_0001, 6'd1,  32'h8000_0000);
        send_request(OP_MAP,  32'h8000_0000, 6'd32, 32'h8000_0001);
        send_request(OP_FIND, 32'h8000_0000, 6'd32, 32'hffff_ffff);
    endtask

    // Random traffic. The first calm_items beats run with no idling on
    // either side.
    task automatic test_random_mix(input int count, input int calm_items);
        op_t         op;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [31:0] client;
        for (int n = 0; n < count; n++)
        begin
            steady = (n < calm_items);
            pick_request(op, addr, len, client);
            send_request(op, addr, len, client);
        end
        steady = 1'b0;
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register fills, a second result waits behind it and the
    // block has to drop in_ready.
    task automatic test_backpressure();
        op_t         op;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [31:0] client;
        steady = 1'b1;
        hold_flag = ~hold_flag;
        for (int n = 0; n < 12; n++)
        begin
            pick_request(op, addr, len, client);
            send_request(op, addr, len, client);
        end
        steady = 1'b0;
    endtask

    // Fills every entry, then checks that a new prefix is refused as full,
    // that a conflict is still reported ahead of a full table, and that an
    // overwrite and a find still work.
    task automatic test_fill_to_capacity();
        int          tries;
        logic [31:0] last_prefix;
        tries = 0;
        while (slots_filled < TABLE_ENTRIES && tries < 1000)
        begin
            send_request(OP_MAP, $urandom(), 6'd32, $urandom());
            tries++;
        end
        for (int n = 0; n < 3; n++)
            send_request(OP_MAP, $urandom(), 6'd32, $urandom());
        last_prefix = slot_prefix[TABLE_ENTRIES - 1];
        send_request(OP_MAP,  last_prefix, 6'd20, $urandom());
        send_request(OP_MAP,  last_prefix, 6'd32, 32'h0000_0000);
        send_request(OP_FIND, last_prefix, 6'd32, $urandom());
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_prefix[i] = '0;
            slot_len[i] = '0;
            slot_client[i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_mix(400, 100);
        test_backpressure();
        test_fill_to_capacity();
        test_random_mix(950, 0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        // Leave room for any stray beat to show up before judging the run.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d expected result beats never arrived", pending_replies.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/pct_pkg.sv
hw/rtl/pct_cell.sv
hw/rtl/pct_chain.sv
hw/rtl/prefix_client_table_top.sv
tb/prefix_client_table_top_tb.sv
